// ----- rtl/zobrist_hash_update_core_assert.svh -----
// Assertion macros for the Zobrist hash update core.
`ifndef ZOBRIST_HASH_UPDATE_CORE_ASSERT_SVH
`define ZOBRIST_HASH_UPDATE_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define ZHU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zobrist hash update core: check failed");

// Antecedent implies consequent in the next cycle.
`define ZHU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zobrist hash update core: check failed");

`endif

// ----- rtl/zhu_pkg.sv -----
// Shared types and constants of the Zobrist hash update core.
`default_nettype none

package zhu_pkg;

    // Generator constants
    localparam logic [63:0] MT_SEED = 64'd123456789;
    localparam logic [63:0] MT_MULT = 64'd6364136223846793005;
    localparam logic [63:0] MT_MAG  = 64'hB5026F5AA96619E9;
    localparam logic [63:0] MT_UPPER_MASK = 64'hFFFFFFFF80000000;
    localparam logic [63:0] TEMPER_B = 64'h5555555555555555;
    localparam logic [63:0] TEMPER_C = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TEMPER_D = 64'hFFF7EEE000000000;
    localparam int unsigned MT_N = 312;
    localparam int unsigned MT_M = 156;

    // Key layout
    localparam int unsigned KEY_COUNT   = 793;
    localparam int unsigned PIECE_KEYS  = 768;
    localparam int unsigned SIDE_BASE   = 768;
    localparam int unsigned CASTLE_BASE = 769;
    localparam int unsigned EP_BASE     = 785;

    // Field codes
    localparam logic [1:0] OP_MOVE   = 2'd0;
    localparam logic [1:0] OP_KSIDE  = 2'd1;
    localparam logic [1:0] OP_QSIDE  = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam logic [3:0] NO_PIECE   = 4'd12;
    localparam logic [3:0] EP_CAPTURE = 4'd13;
    localparam logic [3:0] W_PAWN = 4'd0;
    localparam logic [3:0] W_ROOK = 4'd1;
    localparam logic [3:0] W_KING = 4'd5;
    localparam logic [3:0] B_PAWN = 4'd6;
    localparam logic [3:0] B_ROOK = 4'd7;
    localparam logic [3:0] B_KING = 4'd11;
    localparam logic [3:0] EP_NONE = 4'd8;

    // Key table build sequencer
    typedef enum logic [1:0] {
        ST_SEED,
        ST_TWIST,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/zobrist_hash_update_core.sv -----
// Top level of the Zobrist hash update core: key table build and hash datapath.
`default_nettype none

// After reset the core builds its 793 keys from a 64-bit Mersenne Twister
// and holds busy high meanwhile: 312 seed steps and 793 twist steps.
// Then busy stays low and an item is taken on every cycle start is high,
// back to back. The key reads and the item register at the transfer edge,
// and the XOR then folds them into the result register behind o_valid and
// the hash, which are shown for a single cycle per item.
// The receiver cannot stall, so the result must be taken then.
module zobrist_hash_update_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [63:0] i_old_hash,
    input  wire logic        i_white_to_move,
    input  wire logic [3:0]  i_piece_type,
    input  wire logic [5:0]  i_from_square,
    input  wire logic [5:0]  i_to_square,
    input  wire logic [3:0]  i_captured,
    input  wire logic [3:0]  i_promotion_type,
    input  wire logic [3:0]  i_old_castling,
    input  wire logic [3:0]  i_new_castling,
    input  wire logic [3:0]  i_old_ep_file,
    input  wire logic [3:0]  i_new_ep_file,
    output logic             o_valid,
    output logic [63:0]      o_moved_hash
);

`include "zobrist_hash_update_core_assert.svh"

    // ---------------- key table build ----------------
    zhu_pkg::t_state r_state, n_state;
    logic [8:0]  r_idx, n_idx;
    logic [2:0]  r_ph, n_ph;
    logic [9:0]  r_key, n_key;
    logic [63:0] r_prev, r_prod, r_acc, r_yhi, r_ylo, r_tw;

    logic [63:0] mt_mem [zhu_pkg::MT_N];
    logic [63:0] r_mt_q;
    logic        mt_we;
    logic [8:0]  mt_wa, mt_ra;
    logic [63:0] mt_wd;

    logic [63:0] seed_x, seed_val, tw_y, tw_v, tmp_a, tmp_b, tmp_c, key_val;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [8:0]  idx_inc, idx_mid;
    logic        key_we;

    assign idx_inc = (r_idx == 9'(zhu_pkg::MT_N - 1)) ? 9'd0 : r_idx + 9'd1;
    assign idx_mid = (r_idx < 9'(zhu_pkg::MT_M)) ? r_idx + 9'(zhu_pkg::MT_M)
                                                 : r_idx - 9'(zhu_pkg::MT_M);

    // Seed recurrence operands, one 32x32 partial product per phase
    assign seed_x = r_prev ^ (r_prev >> 62);
    assign mul_a  = (r_ph == 3'd1) ? seed_x[63:32] : seed_x[31:0];
    assign mul_b  = (r_ph == 3'd2) ? zhu_pkg::MT_MULT[63:32] : zhu_pkg::MT_MULT[31:0];
    assign mul_p  = 64'(mul_a) * 64'(mul_b);
    assign seed_val = (r_idx == 9'd0) ? zhu_pkg::MT_SEED : r_acc + 64'(r_idx);

    // Twist of one state word
    assign tw_y = (r_yhi & zhu_pkg::MT_UPPER_MASK) | (r_ylo & ~zhu_pkg::MT_UPPER_MASK);
    assign tw_v = r_mt_q ^ (tw_y >> 1) ^ (tw_y[0] ? zhu_pkg::MT_MAG : 64'd0);

    // Temper the twisted word into a key
    assign tmp_a   = r_tw ^ ((r_tw >> 29) & zhu_pkg::TEMPER_B);
    assign tmp_b   = tmp_a ^ ((tmp_a << 17) & zhu_pkg::TEMPER_C);
    assign tmp_c   = tmp_b ^ ((tmp_b << 37) & zhu_pkg::TEMPER_D);
    assign key_val = tmp_c ^ (tmp_c >> 43);
    assign key_we  = (r_state == zhu_pkg::ST_TWIST) && (r_ph == 3'd4);

    // Sequencer next state and memory controls
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_ph    = r_ph;
        n_key   = r_key;
        mt_we   = 1'b0;
        mt_wa   = r_idx;
        mt_wd   = seed_val;
        mt_ra   = r_idx;
        unique case (r_state)
            zhu_pkg::ST_SEED: begin
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd4) begin
                    mt_we = 1'b1;
                    n_ph  = 3'd0;
                    n_idx = idx_inc;
                    if (r_idx == 9'(zhu_pkg::MT_N - 1)) begin
                        n_state = zhu_pkg::ST_TWIST;
                    end
                end
            end
            zhu_pkg::ST_TWIST: begin
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd1) begin
                    mt_ra = idx_inc;
                end else if (r_ph == 3'd2) begin
                    mt_ra = idx_mid;
                end
                if (r_ph == 3'd3) begin
                    mt_we = 1'b1;
                    mt_wd = tw_v;
                end
                if (r_ph == 3'd4) begin
                    n_ph  = 3'd0;
                    n_idx = idx_inc;
                    n_key = r_key + 10'd1;
                    if (r_key == 10'(zhu_pkg::KEY_COUNT - 1)) begin
                        n_state = zhu_pkg::ST_RUN;
                    end
                end
            end
            zhu_pkg::ST_RUN: begin
                n_state = zhu_pkg::ST_RUN;
            end
            default: n_state = zhu_pkg::ST_SEED;
        endcase
    end

    // Hold sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zhu_pkg::ST_SEED;
            r_idx   <= 9'd0;
            r_ph    <= 3'd0;
            r_key   <= 10'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ph    <= n_ph;
            r_key   <= n_key;
        end
    end

    // Advance seed and twist datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (r_ph == 3'd1) begin
            r_acc <= r_prod;
        end else if (r_ph == 3'd2 || r_ph == 3'd3) begin
            r_acc <= r_acc + {r_prod[31:0], 32'd0};
        end
        if (r_state == zhu_pkg::ST_SEED && r_ph == 3'd4) begin
            r_prev <= seed_val;
        end
        if (r_ph == 3'd1) begin
            r_yhi <= r_mt_q;
        end
        if (r_ph == 3'd2) begin
            r_ylo <= r_mt_q;
        end
        if (r_ph == 3'd3) begin
            r_tw <= tw_v;
        end
    end

    // Generator state memory
    always_ff @(posedge i_clk) begin
        if (mt_we) begin
            mt_mem[mt_wa] <= mt_wd;
        end
        r_mt_q <= mt_mem[mt_ra];
    end

    // ---------------- key stores ----------------
    logic [63:0] pc0_mem [zhu_pkg::PIECE_KEYS];
    logic [63:0] pc1_mem [zhu_pkg::PIECE_KEYS];
    logic [63:0] cs_mem [16];
    logic [63:0] ep_mem [8];
    logic [63:0] r_side;
    logic [63:0] r_qa, r_qb, r_qc, r_qd, r_qoc, r_qnc, r_qoe, r_qne;
    logic [9:0]  ad_a, ad_b, ad_c, ad_d;
    logic [9:0]  cs_off, ep_off;

    assign cs_off = r_key - 10'(zhu_pkg::CASTLE_BASE);
    assign ep_off = r_key - 10'(zhu_pkg::EP_BASE);

    // Write keys as the generator produces them
    always_ff @(posedge i_clk) begin
        if (key_we && r_key < 10'(zhu_pkg::PIECE_KEYS)) begin
            pc0_mem[r_key] <= key_val;
            pc1_mem[r_key] <= key_val;
        end
        if (key_we && r_key == 10'(zhu_pkg::SIDE_BASE)) begin
            r_side <= key_val;
        end
        if (key_we && r_key >= 10'(zhu_pkg::CASTLE_BASE)
                   && r_key < 10'(zhu_pkg::EP_BASE)) begin
            cs_mem[cs_off[3:0]] <= key_val;
        end
        if (key_we && r_key >= 10'(zhu_pkg::EP_BASE)) begin
            ep_mem[ep_off[2:0]] <= key_val;
        end
        r_qa  <= pc0_mem[ad_a];
        r_qb  <= pc0_mem[ad_b];
        r_qc  <= pc1_mem[ad_c];
        r_qd  <= pc1_mem[ad_d];
        r_qoc <= cs_mem[i_old_castling];
        r_qnc <= cs_mem[i_new_castling];
        r_qoe <= ep_mem[i_old_ep_file[2:0]];
        r_qne <= ep_mem[i_new_ep_file[2:0]];
    end

    // ---------------- hash datapath ----------------
    logic       accept;
    logic       castle, piece_ok, promo_ok, is_ep;
    logic [3:0] king_p, rook_p, ep_pawn, b_piece;
    logic [5:0] base_sq, ep_sq;
    logic       m_a, m_b, m_c, m_d;
    logic       r_s_v, r_ma, r_mb, r_mc, r_md, r_moe, r_mne;
    logic [63:0] r_s_hash;

    assign busy   = (r_state != zhu_pkg::ST_RUN);
    assign accept = start && !busy;

    assign castle   = (i_operation == zhu_pkg::OP_KSIDE) || (i_operation == zhu_pkg::OP_QSIDE);
    assign piece_ok = (i_piece_type < zhu_pkg::NO_PIECE);
    assign is_ep    = (i_captured == zhu_pkg::EP_CAPTURE);
    assign promo_ok = (i_promotion_type < zhu_pkg::NO_PIECE) && !is_ep;
    assign king_p   = i_white_to_move ? zhu_pkg::W_KING : zhu_pkg::B_KING;
    assign rook_p   = i_white_to_move ? zhu_pkg::W_ROOK : zhu_pkg::B_ROOK;
    assign ep_pawn  = i_white_to_move ? zhu_pkg::B_PAWN : zhu_pkg::W_PAWN;
    assign base_sq  = i_white_to_move ? 6'd0 : 6'd56;
    assign ep_sq    = i_white_to_move ? i_to_square - 6'd8 : i_to_square + 6'd8;
    // A promotion replaces the pawn key at the destination
    assign b_piece  = promo_ok ? i_promotion_type : i_piece_type;

    // Select the four piece-square reads
    always_comb begin
        if (castle) begin
            ad_a = {king_p, base_sq + 6'd4};
            ad_b = {king_p, base_sq + ((i_operation == zhu_pkg::OP_KSIDE) ? 6'd6 : 6'd2)};
            ad_c = {rook_p, base_sq + ((i_operation == zhu_pkg::OP_KSIDE) ? 6'd7 : 6'd0)};
            ad_d = {rook_p, base_sq + ((i_operation == zhu_pkg::OP_KSIDE) ? 6'd5 : 6'd3)};
            m_a  = 1'b1;
            m_b  = 1'b1;
            m_c  = 1'b1;
            m_d  = 1'b1;
        end else begin
            ad_a = {i_piece_type[3:0], i_from_square};
            ad_b = {b_piece, i_to_square};
            ad_c = is_ep ? {ep_pawn, ep_sq} : {i_captured, i_to_square};
            ad_d = 10'd0;
            m_a  = piece_ok;
            m_b  = promo_ok || piece_ok;
            m_c  = is_ep || (i_captured < zhu_pkg::NO_PIECE);
            m_d  = 1'b0;
        end
        // Keep out-of-range codes inside the table
        if (!m_a) ad_a = 10'd0;
        if (!m_b) ad_b = 10'd0;
        if (!m_c) ad_c = 10'd0;
    end

    // Register the item alongside the key reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else begin
            r_s_v <= accept;
        end
        r_s_hash <= i_old_hash;
        r_ma  <= m_a;
        r_mb  <= m_b;
        r_mc  <= m_c;
        r_md  <= m_d;
        r_moe <= (i_old_ep_file < zhu_pkg::EP_NONE);
        r_mne <= (i_new_ep_file < zhu_pkg::EP_NONE);
    end

    // Fold the keys into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s_v;
        end
        o_moved_hash <= r_s_hash
                    ^ (r_ma ? r_qa : 64'd0) ^ (r_mb ? r_qb : 64'd0)
                    ^ (r_mc ? r_qc : 64'd0) ^ (r_md ? r_qd : 64'd0)
                    ^ r_qoc ^ r_qnc
                    ^ (r_moe ? r_qoe : 64'd0) ^ (r_mne ? r_qne : 64'd0)
                    ^ r_side;
    end

    // ---------------- checks ----------------
    `ZHU_ASSERT_NEXT(a_ready_stays, i_clk, i_rst_n, !busy, !busy)
    `ZHU_ASSERT_NEXT(a_accept_stages, i_clk, i_rst_n, accept, r_s_v)
    `ZHU_ASSERT_SAME(a_result_source, i_clk, i_rst_n, o_valid, $past(r_s_v) && !busy)
    `ZHU_ASSERT_SAME(a_keys_done, i_clk, i_rst_n, !busy, r_key == 10'(zhu_pkg::KEY_COUNT))

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the Zobrist hash update core: scoreboard class plus directed and random moves.
`timescale 1ns / 1ps

module tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [63:0] i_old_hash;
    logic        i_white_to_move;
    logic [3:0]  i_piece_type;
    logic [5:0]  i_from_square;
    logic [5:0]  i_to_square;
    logic [3:0]  i_captured;
    logic [3:0]  i_promotion_type;
    logic [3:0]  i_old_castling;
    logic [3:0]  i_new_castling;
    logic [3:0]  i_old_ep_file;
    logic [3:0]  i_new_ep_file;
    logic        o_valid;
    logic [63:0] o_moved_hash;

    int error_count = 0;
    int idle_pct = 0;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] hash;
        logic        white;
        logic [3:0]  piece;
        logic [5:0]  from_sq;
        logic [5:0]  to_sq;
        logic [3:0]  cap;
        logic [3:0]  promo;
        logic [3:0]  oc;
        logic [3:0]  nc;
        logic [3:0]  oe;
        logic [3:0]  ne;
    } t_move;

    zobrist_hash_update_core dut (.*);

    // Clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Report one mismatch and count it
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Hash predictor with its own copy of the key table
    class hash_scoreboard;
        logic [63:0] keys [zhu_pkg::KEY_COUNT];
        logic [63:0] pending [$];
        int          moves_seen;
        int          hashes_checked;

        function new();
            logic [63:0] st [zhu_pkg::MT_N];
            logic [63:0] y, z;
            int          pos;
            st[0] = zhu_pkg::MT_SEED;
            for (int i = 1; i < zhu_pkg::MT_N; i++)
                st[i] = zhu_pkg::MT_MULT * (st[i-1] ^ (st[i-1] >> 62)) + 64'(i);
            pos = zhu_pkg::MT_N;
            for (int k = 0; k < zhu_pkg::KEY_COUNT; k++) begin
                if (pos >= zhu_pkg::MT_N) begin
                    for (int i = 0; i < zhu_pkg::MT_N; i++) begin
                        y = (st[i] & zhu_pkg::MT_UPPER_MASK)
                          | (st[(i+1) % zhu_pkg::MT_N] & 64'h7FFFFFFF);
                        st[i] = st[(i + zhu_pkg::MT_M) % zhu_pkg::MT_N] ^ (y >> 1)
                              ^ (y[0] ? zhu_pkg::MT_MAG : 64'd0);
                    end
                    pos = 0;
                end
                z = st[pos];
                pos++;
                z ^= (z >> 29) & zhu_pkg::TEMPER_B;
                z ^= (z << 17) & zhu_pkg::TEMPER_C;
                z ^= (z << 37) & zhu_pkg::TEMPER_D;
                z ^= z >> 43;
                keys[k] = z;
            end
        endfunction

        function logic [63:0] pkey(input logic [3:0] p, input logic [5:0] sq);
            if (p >= zhu_pkg::NO_PIECE) return 64'd0;
            return keys[int'(p) * 64 + int'(sq)];
        endfunction

        function logic [63:0] updated_hash(input t_move m);
            logic [63:0] h;
            logic [5:0]  base, ep_sq;
            logic [3:0]  king, rook;
            h = m.hash;
            if (m.op == zhu_pkg::OP_KSIDE || m.op == zhu_pkg::OP_QSIDE) begin
                base = m.white ? 6'd0 : 6'd56;
                king = m.white ? zhu_pkg::W_KING : zhu_pkg::B_KING;
                rook = m.white ? zhu_pkg::W_ROOK : zhu_pkg::B_ROOK;
                h ^= pkey(king, base + 6'd4);
                h ^= pkey(king, base + ((m.op == zhu_pkg::OP_KSIDE) ? 6'd6 : 6'd2));
                h ^= pkey(rook, base + ((m.op == zhu_pkg::OP_KSIDE) ? 6'd7 : 6'd0));
                h ^= pkey(rook, base + ((m.op == zhu_pkg::OP_KSIDE) ? 6'd5 : 6'd3));
            end else begin
                h ^= pkey(m.piece, m.from_sq) ^ pkey(m.piece, m.to_sq);
                if (m.cap == zhu_pkg::EP_CAPTURE) begin
                    ep_sq = m.white ? m.to_sq - 6'd8 : m.to_sq + 6'd8;
                    h ^= pkey(m.white ? zhu_pkg::B_PAWN : zhu_pkg::W_PAWN, ep_sq);
                end else begin
                    if (m.cap < zhu_pkg::NO_PIECE) h ^= pkey(m.cap, m.to_sq);
                    if (m.promo < zhu_pkg::NO_PIECE)
                        h ^= pkey(m.piece, m.to_sq) ^ pkey(m.promo, m.to_sq);
                end
            end
            h ^= keys[zhu_pkg::CASTLE_BASE + m.oc] ^ keys[zhu_pkg::CASTLE_BASE + m.nc];
            if (m.oe < zhu_pkg::EP_NONE) h ^= keys[zhu_pkg::EP_BASE + m.oe];
            if (m.ne < zhu_pkg::EP_NONE) h ^= keys[zhu_pkg::EP_BASE + m.ne];
            h ^= keys[zhu_pkg::SIDE_BASE];
            return h;
        endfunction

        function void note_move(input t_move m);
            pending.push_back(updated_hash(m));
            moves_seen++;
        endfunction

        task check_hash(input logic [63:0] got);
            logic [63:0] want;
            hashes_checked++;
            if (pending.size() == 0) begin
                report("unexpected hash", got, 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got !== want) report("moved_hash", got, want);
        endtask
    endclass

    hash_scoreboard sb = new();

    // Note transfers and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_move({i_operation, i_old_hash, i_white_to_move, i_piece_type,
                              i_from_square, i_to_square, i_captured, i_promotion_type,
                              i_old_castling, i_new_castling, i_old_ep_file, i_new_ep_file});
            if (o_valid) sb.check_hash(o_moved_hash);
        end
    end

    // Drive one move and hold it until the transfer
    task automatic send_move(input t_move m);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        {i_operation, i_old_hash, i_white_to_move, i_piece_type, i_from_square,
         i_to_square, i_captured, i_promotion_type, i_old_castling, i_new_castling,
         i_old_ep_file, i_new_ep_file} <= m;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    function automatic t_move random_move();
        t_move        m;
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        m = bits[$bits(t_move)-1:0];
        m.hash = {$urandom, $urandom};
        // Mostly legal-range codes, with some out-of-range noise
        if ($urandom_range(9, 0) != 0) begin
            m.op    = 2'($urandom_range(2, 0));
            m.piece = 4'($urandom_range(11, 0));
            m.cap   = 4'($urandom_range(13, 0));
            m.promo = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(11, 0))
                                                  : zhu_pkg::NO_PIECE;
            m.oe    = 4'($urandom_range(8, 0));
            m.ne    = 4'($urandom_range(8, 0));
        end
        return m;
    endfunction

    function automatic t_move plain_move(input logic [1:0] op, input logic white,
                                         input logic [3:0] piece, input logic [5:0] f,
                                         input logic [5:0] t, input logic [3:0] cap,
                                         input logic [3:0] promo);
        t_move m;
        m = '{op, 64'h0123456789ABCDEF, white, piece, f, t, cap, promo,
              4'hF, 4'h0, zhu_pkg::EP_NONE, zhu_pkg::EP_NONE};
        return m;
    endfunction

    // Drop start and wait for every outstanding hash
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_move m;
        start = 1'b0;
        i_rst_n = 1'b0;
        {i_operation, i_old_hash, i_white_to_move, i_piece_type, i_from_square,
         i_to_square, i_captured, i_promotion_type, i_old_castling, i_new_castling,
         i_old_ep_file, i_new_ep_file} = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: castles, en passant wrap, promotion, out-of-range codes
        send_move(plain_move(zhu_pkg::OP_KSIDE, 1'b1, 4'd0, 6'd0, 6'd0, 4'd0, 4'd0));
        send_move(plain_move(zhu_pkg::OP_QSIDE, 1'b1, 4'd0, 6'd0, 6'd0, 4'd0, 4'd0));
        send_move(plain_move(zhu_pkg::OP_KSIDE, 1'b0, 4'd15, 6'd63, 6'd63, 4'd15, 4'd15));
        send_move(plain_move(zhu_pkg::OP_QSIDE, 1'b0, 4'd3, 6'd1, 6'd2, 4'd3, 4'd3));
        send_move(plain_move(zhu_pkg::OP_SPARE, 1'b1, 4'd2, 6'd1, 6'd18,
                             zhu_pkg::NO_PIECE, zhu_pkg::NO_PIECE));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b1, zhu_pkg::W_PAWN, 6'd36, 6'd43,
                             zhu_pkg::EP_CAPTURE, 4'd4));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b1, zhu_pkg::W_PAWN, 6'd0, 6'd3,
                             zhu_pkg::EP_CAPTURE, zhu_pkg::NO_PIECE));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b0, zhu_pkg::B_PAWN, 6'd62, 6'd61,
                             zhu_pkg::EP_CAPTURE, zhu_pkg::NO_PIECE));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b1, zhu_pkg::W_PAWN, 6'd52, 6'd60,
                             4'd9, 4'd4));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b0, zhu_pkg::B_PAWN, 6'd8, 6'd0,
                             zhu_pkg::NO_PIECE, 4'd10));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b1, 4'd13, 6'd8, 6'd16, 4'd2, 4'd4));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b1, 4'd15, 6'd8, 6'd16,
                             zhu_pkg::EP_CAPTURE, zhu_pkg::NO_PIECE));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b0, zhu_pkg::B_KING, 6'd63, 6'd0,
                             4'd14, 4'd13));
        send_move(plain_move(zhu_pkg::OP_MOVE, 1'b0, 4'd4, 6'd0, 6'd63, 4'd15, 4'd15));
        m = plain_move(zhu_pkg::OP_MOVE, 1'b1, 4'd1, 6'd7, 6'd5, 4'd11, zhu_pkg::NO_PIECE);
        m.oc = 4'd0; m.nc = 4'hF; m.oe = 4'd0; m.ne = 4'd7; m.hash = '1;
        send_move(m);
        m.oe = 4'd9; m.ne = 4'd15; m.hash = '0;
        send_move(m);
        m.oe = 4'd8; m.ne = 4'd3;
        send_move(m);

        // Hold off until every expected hash is back
        drain();

        // Random phases: no idling, heavy idling, moderate idling, no idling again
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 75 : (ph == 2) ? 38 : 0;
            repeat (225) send_move(random_move());
        end

        drain();
        repeat (10) @(negedge i_clk);
        $display("Covered %0d moves (castles, en passant, promotions, out-of-range codes),",
                 sb.moves_seen);
        $display("checked %0d new hashes under several sender idle rates.", sb.hashes_checked);
        if (error_count == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Timeout
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
